// ===== sv/ecal_pkg.sv =====
// Shared constants and helper functions for the epoch to calendar conversion.
`timescale 1ns / 1ps

package ecal_pkg;

   // Field widths
   localparam int unsigned SECS_W   = 31;
   localparam int unsigned DAYS_W   = 15;
   localparam int unsigned SOD_W    = 17;
   localparam int unsigned YEAR_W   = 11;
   localparam int unsigned MONTH_W  = 4;
   localparam int unsigned DAY_W    = 5;
   localparam int unsigned HOUR_W   = 5;
   localparam int unsigned MINUTE_W = 6;
   localparam int unsigned SECOND_W = 6;
   localparam int unsigned DOY_W    = 9;

   // Calendar constants
   localparam int unsigned FIRST_YEAR     = 1970;
   localparam int unsigned SEC_PER_DAY    = 86400;
   localparam int unsigned SEC_PER_HOUR   = 3600;
   localparam int unsigned SEC_PER_MIN    = 60;
   localparam int unsigned DAYS_PER_CYCLE = 1461;   // four years, one of them leap
   localparam int unsigned DAYS_YEAR      = 365;

   // Reciprocals for constant division, each estimate is exact or one short.
   // days = (secs >> 7) / 675, scaled by 2^34
   localparam int unsigned DAY_RECIP   = 25451658;
   localparam int unsigned DAY_SHIFT   = 34;
   // cycles = days / 1461, scaled by 2^26
   localparam int unsigned CYCLE_RECIP = 45933;
   localparam int unsigned CYCLE_SHIFT = 26;
   // hours = (sod >> 4) / 225, scaled by 2^20
   localparam int unsigned HOUR_RECIP  = 4660;
   localparam int unsigned HOUR_SHIFT  = 20;
   // minutes = (rest >> 2) / 15, scaled by 2^14
   localparam int unsigned MIN_RECIP   = 1092;
   localparam int unsigned MIN_SHIFT   = 14;

   // Month codes
   typedef enum logic [MONTH_W-1:0] {
      MON_JAN = 4'd0, MON_FEB = 4'd1, MON_MAR = 4'd2, MON_APR = 4'd3,
      MON_MAY = 4'd4, MON_JUN = 4'd5, MON_JUL = 4'd6, MON_AUG = 4'd7,
      MON_SEP = 4'd8, MON_OCT = 4'd9, MON_NOV = 4'd10, MON_DEC = 4'd11
   } month_type;

   // First day of a month within the year, counted from 0
   function automatic logic [DOY_W-1:0] month_start(input logic [MONTH_W-1:0] month,
                                                    input logic leap);
      logic [DOY_W-1:0] base;
      logic [DOY_W-1:0] extra;
      case (month)
         MON_JAN: base = 9'd0;
         MON_FEB: base = 9'd31;
         MON_MAR: base = 9'd59;
         MON_APR: base = 9'd90;
         MON_MAY: base = 9'd120;
         MON_JUN: base = 9'd151;
         MON_JUL: base = 9'd181;
         MON_AUG: base = 9'd212;
         MON_SEP: base = 9'd243;
         MON_OCT: base = 9'd273;
         MON_NOV: base = 9'd304;
         MON_DEC: base = 9'd334;
         default: base = 9'd0;
      endcase
      extra = (leap && (month >= MON_MAR)) ? 9'd1 : 9'd0;
      return base + extra;
   endfunction

endpackage

// ===== sv/ecal_day_split.sv =====
// Splits epoch seconds into whole days and seconds of the day over three stages.
`timescale 1ns / 1ps

module ecal_day_split
   import ecal_pkg::*;
(
   input  logic                clock,
   input  logic                adv,
   input  logic [SECS_W-1:0]   secs,
   output logic [DAYS_W-1:0]   days,
   output logic [SOD_W-1:0]    sod
);

   logic [48:0]        est_prod;
   logic [SECS_W-1:0]  secs_a_ff, secs_a_in;
   logic [DAYS_W-1:0]  q_a_ff, q_a_in;
   logic [SECS_W-1:0]  secs_b_ff, secs_b_in;
   logic [DAYS_W-1:0]  q_b_ff, q_b_in;
   logic [SECS_W-1:0]  prod_b_ff, prod_b_in;
   logic [SECS_W-1:0]  rem;
   logic [DAYS_W-1:0]  days_ff, days_in;
   logic [SOD_W-1:0]   sod_ff, sod_in;

   // Estimate the day count by reciprocal multiply
   assign est_prod  = 49'(secs[SECS_W-1:7]) * 49'(DAY_RECIP);
   assign secs_a_in = secs;
   assign q_a_in    = est_prod[DAY_SHIFT +: DAYS_W];

   // Multiply back the estimate
   assign secs_b_in = secs_a_ff;
   assign q_b_in    = q_a_ff;
   assign prod_b_in = SECS_W'(32'(q_a_ff) * SEC_PER_DAY);

   // Correct the estimate by at most one day
   always_comb begin
      rem = secs_b_ff - prod_b_ff;
      if (rem >= SECS_W'(SEC_PER_DAY)) begin
         days_in = q_b_ff + 1'b1;
         sod_in  = SOD_W'(rem - SECS_W'(SEC_PER_DAY));
      end else begin
         days_in = q_b_ff;
         sod_in  = SOD_W'(rem);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         secs_a_ff <= secs_a_in;
         q_a_ff    <= q_a_in;
         secs_b_ff <= secs_b_in;
         q_b_ff    <= q_b_in;
         prod_b_ff <= prod_b_in;
         days_ff   <= days_in;
         sod_ff    <= sod_in;
      end
   end

   assign days = days_ff;
   assign sod  = sod_ff;

endmodule

// ===== sv/ecal_date_path.sv =====
// Turns a day count into year, month and day of month over six stages.
`timescale 1ns / 1ps

module ecal_date_path
   import ecal_pkg::*;
(
   input  logic                clock,
   input  logic                adv,
   input  logic [DAYS_W-1:0]   days,
   output logic [YEAR_W-1:0]   year,
   output logic [MONTH_W-1:0]  month_index,
   output logic [DAY_W-1:0]    day_of_month
);

   logic [30:0]          cyc_prod;
   logic [DAYS_W-1:0]    days_d_ff, days_d_in;
   logic [4:0]           cq_d_ff, cq_d_in;
   logic [DAYS_W-1:0]    days_e_ff, days_e_in;
   logic [4:0]           cq_e_ff, cq_e_in;
   logic [DAYS_W-1:0]    cprod_e_ff, cprod_e_in;
   logic [DAYS_W-1:0]    crem;
   logic [4:0]           cyc_f_ff, cyc_f_in;
   logic [10:0]          dc_f_ff, dc_f_in;
   logic [1:0]           yi;
   logic [DOY_W-1:0]     doy_g_ff, doy_g_in;
   logic                 leap_g_ff, leap_g_in;
   logic [YEAR_W-1:0]    year_g_ff, year_g_in;
   logic [MONTH_W-1:0]   month_h_ff, month_h_in;
   logic [DOY_W-1:0]     doy_h_ff, doy_h_in;
   logic                 leap_h_ff, leap_h_in;
   logic [YEAR_W-1:0]    year_h_ff, year_h_in;
   logic [YEAR_W-1:0]    year_ff, year_in;
   logic [MONTH_W-1:0]   month_ff, month_in;
   logic [DAY_W-1:0]     day_ff, day_in;

   // Estimate whole four-year cycles
   assign cyc_prod  = 31'(days) * 31'(CYCLE_RECIP);
   assign days_d_in = days;
   assign cq_d_in   = cyc_prod[CYCLE_SHIFT +: 5];

   // Multiply back the cycle estimate
   assign days_e_in  = days_d_ff;
   assign cq_e_in    = cq_d_ff;
   assign cprod_e_in = DAYS_W'(cq_d_ff) * DAYS_W'(DAYS_PER_CYCLE);

   // Correct the cycle count by at most one
   always_comb begin
      crem = days_e_ff - cprod_e_ff;
      if (crem >= DAYS_W'(DAYS_PER_CYCLE)) begin
         cyc_f_in = cq_e_ff + 1'b1;
         dc_f_in  = 11'(crem - DAYS_W'(DAYS_PER_CYCLE));
      end else begin
         cyc_f_in = cq_e_ff;
         dc_f_in  = 11'(crem);
      end
   end

   // Place the day within its cycle: 1970 and 1971 plain, the third year leap
   always_comb begin
      if (dc_f_ff < 11'd365) begin
         yi       = 2'd0;
         doy_g_in = DOY_W'(dc_f_ff);
      end else if (dc_f_ff < 11'd730) begin
         yi       = 2'd1;
         doy_g_in = DOY_W'(dc_f_ff - 11'd365);
      end else if (dc_f_ff < 11'd1096) begin
         yi       = 2'd2;
         doy_g_in = DOY_W'(dc_f_ff - 11'd730);
      end else begin
         yi       = 2'd3;
         doy_g_in = DOY_W'(dc_f_ff - 11'd1096);
      end
      leap_g_in = (yi == 2'd2);
      year_g_in = YEAR_W'(FIRST_YEAR) + {4'd0, cyc_f_ff, 2'b00} + {9'd0, yi};
   end

   // Pick the last month whose first day is not past the day of year
   always_comb begin
      month_h_in = MON_JAN;
      for (int m = 1; m < 12; m++) begin
         if (doy_g_ff >= month_start(MONTH_W'(m), leap_g_ff)) begin
            month_h_in = MONTH_W'(m);
         end
      end
      doy_h_in  = doy_g_ff;
      leap_h_in = leap_g_ff;
      year_h_in = year_g_ff;
   end

   // Day within the month, counted from one
   assign year_in  = year_h_ff;
   assign month_in = month_h_ff;
   assign day_in   = DAY_W'(doy_h_ff - month_start(month_h_ff, leap_h_ff) + 9'd1);

   always_ff @(posedge clock) begin
      if (adv) begin
         days_d_ff  <= days_d_in;
         cq_d_ff    <= cq_d_in;
         days_e_ff  <= days_e_in;
         cq_e_ff    <= cq_e_in;
         cprod_e_ff <= cprod_e_in;
         cyc_f_ff   <= cyc_f_in;
         dc_f_ff    <= dc_f_in;
         doy_g_ff   <= doy_g_in;
         leap_g_ff  <= leap_g_in;
         year_g_ff  <= year_g_in;
         month_h_ff <= month_h_in;
         doy_h_ff   <= doy_h_in;
         leap_h_ff  <= leap_h_in;
         year_h_ff  <= year_h_in;
         year_ff    <= year_in;
         month_ff   <= month_in;
         day_ff     <= day_in;
      end
   end

   assign year         = year_ff;
   assign month_index  = month_ff;
   assign day_of_month = day_ff;

endmodule

// ===== sv/ecal_time_path.sv =====
// Splits seconds of the day into hour, minute and second over six stages.
`timescale 1ns / 1ps

module ecal_time_path
   import ecal_pkg::*;
(
   input  logic                 clock,
   input  logic                 adv,
   input  logic [SOD_W-1:0]     sod,
   output logic [HOUR_W-1:0]    hour_of_day,
   output logic [MINUTE_W-1:0]  minute_of_hour,
   output logic [SECOND_W-1:0]  second_of_minute
);

   logic [25:0]          hour_prod;
   logic [20:0]          min_prod;
   logic [SOD_W-1:0]     sod_d_ff, sod_d_in;
   logic [HOUR_W-1:0]    hq_d_ff, hq_d_in;
   logic [SOD_W-1:0]     sod_e_ff, sod_e_in;
   logic [HOUR_W-1:0]    hq_e_ff, hq_e_in;
   logic [SOD_W-1:0]     hprod_e_ff, hprod_e_in;
   logic [SOD_W-1:0]     hrem;
   logic [HOUR_W-1:0]    hour_f_ff, hour_f_in;
   logic [11:0]          shr_f_ff, shr_f_in;
   logic [HOUR_W-1:0]    hour_g_ff, hour_g_in;
   logic [11:0]          shr_g_ff, shr_g_in;
   logic [MINUTE_W-1:0]  mq_g_ff, mq_g_in;
   logic [HOUR_W-1:0]    hour_h_ff, hour_h_in;
   logic [11:0]          shr_h_ff, shr_h_in;
   logic [MINUTE_W-1:0]  mq_h_ff, mq_h_in;
   logic [11:0]          mprod_h_ff, mprod_h_in;
   logic [11:0]          mrem;
   logic [HOUR_W-1:0]    hour_ff, hour_in;
   logic [MINUTE_W-1:0]  minute_ff, minute_in;
   logic [SECOND_W-1:0]  second_ff, second_in;

   // Estimate the hour
   assign hour_prod = 26'(sod[SOD_W-1:4]) * 26'(HOUR_RECIP);
   assign sod_d_in  = sod;
   assign hq_d_in   = hour_prod[HOUR_SHIFT +: HOUR_W];

   // Multiply back the hour estimate
   assign sod_e_in   = sod_d_ff;
   assign hq_e_in    = hq_d_ff;
   assign hprod_e_in = SOD_W'(hq_d_ff) * SOD_W'(SEC_PER_HOUR);

   // Correct the hour by at most one
   always_comb begin
      hrem = sod_e_ff - hprod_e_ff;
      if (hrem >= SOD_W'(SEC_PER_HOUR)) begin
         hour_f_in = hq_e_ff + 1'b1;
         shr_f_in  = 12'(hrem - SOD_W'(SEC_PER_HOUR));
      end else begin
         hour_f_in = hq_e_ff;
         shr_f_in  = 12'(hrem);
      end
   end

   // Estimate the minute
   assign min_prod  = 21'(shr_f_ff[11:2]) * 21'(MIN_RECIP);
   assign hour_g_in = hour_f_ff;
   assign shr_g_in  = shr_f_ff;
   assign mq_g_in   = min_prod[MIN_SHIFT +: MINUTE_W];

   // Multiply back the minute estimate
   assign hour_h_in  = hour_g_ff;
   assign shr_h_in   = shr_g_ff;
   assign mq_h_in    = mq_g_ff;
   assign mprod_h_in = 12'(mq_g_ff) * 12'(SEC_PER_MIN);

   // Correct the minute by at most one, leaving the second
   always_comb begin
      mrem    = shr_h_ff - mprod_h_ff;
      hour_in = hour_h_ff;
      if (mrem >= 12'(SEC_PER_MIN)) begin
         minute_in = mq_h_ff + 1'b1;
         second_in = SECOND_W'(mrem - 12'(SEC_PER_MIN));
      end else begin
         minute_in = mq_h_ff;
         second_in = SECOND_W'(mrem);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sod_d_ff   <= sod_d_in;
         hq_d_ff    <= hq_d_in;
         sod_e_ff   <= sod_e_in;
         hq_e_ff    <= hq_e_in;
         hprod_e_ff <= hprod_e_in;
         hour_f_ff  <= hour_f_in;
         shr_f_ff   <= shr_f_in;
         hour_g_ff  <= hour_g_in;
         shr_g_ff   <= shr_g_in;
         mq_g_ff    <= mq_g_in;
         hour_h_ff  <= hour_h_in;
         shr_h_ff   <= shr_h_in;
         mq_h_ff    <= mq_h_in;
         mprod_h_ff <= mprod_h_in;
         hour_ff    <= hour_in;
         minute_ff  <= minute_in;
         second_ff  <= second_in;
      end
   end

   assign hour_of_day      = hour_ff;
   assign minute_of_hour   = minute_ff;
   assign second_of_minute = second_ff;

endmodule

// ===== sv/epoch_seconds_to_calendar_unit.sv =====
// Top level of the epoch seconds to calendar date and time converter.
//
//   channel   direction  handshake              payload
//   req_      in         req_valid/req_ready    req_seconds_since_epoch
//   rsp_      out        rsp_valid/rsp_ready    rsp_year .. rsp_second_of_minute
//
// Nine register stages: three split seconds into days and seconds of day, six
// turn those into date and time in two side-by-side paths. One beat enters per
// cycle while rsp_ does not stall. The stages follow the chain of reciprocal
// multiply, multiply-back and correct steps; the last is the output register.
// A stall on rsp_ freezes the whole pipe, so nothing is lost or repeated.
// Synchronous reset clears the stage valid bits only.
`timescale 1ns / 1ps

module epoch_seconds_to_calendar_unit
   import ecal_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [SECS_W-1:0]    req_seconds_since_epoch,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [YEAR_W-1:0]    rsp_year,
   output logic [MONTH_W-1:0]   rsp_month_index,
   output logic [DAY_W-1:0]     rsp_day_of_month,
   output logic [HOUR_W-1:0]    rsp_hour_of_day,
   output logic [MINUTE_W-1:0]  rsp_minute_of_hour,
   output logic [SECOND_W-1:0]  rsp_second_of_minute
);

   localparam int unsigned STAGES = 9;

   logic                 adv;
   logic [STAGES-1:0]    valid_ff, valid_in;
   logic [DAYS_W-1:0]    days;
   logic [SOD_W-1:0]     sod;

   // Advance the pipe unless the output beat is held
   assign adv       = !valid_ff[STAGES-1] || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = valid_ff[STAGES-1];

   always_comb begin
      valid_in = valid_ff;
      if (adv) begin
         valid_in = {valid_ff[STAGES-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   ecal_day_split u_split (
      .clock (clock),
      .adv   (adv),
      .secs  (req_seconds_since_epoch),
      .days  (days),
      .sod   (sod)
   );

   ecal_date_path u_date (
      .clock        (clock),
      .adv          (adv),
      .days         (days),
      .year         (rsp_year),
      .month_index  (rsp_month_index),
      .day_of_month (rsp_day_of_month)
   );

   ecal_time_path u_time (
      .clock            (clock),
      .adv              (adv),
      .sod              (sod),
      .hour_of_day      (rsp_hour_of_day),
      .minute_of_hour   (rsp_minute_of_hour),
      .second_of_minute (rsp_second_of_minute)
   );

endmodule

// ===== verif/epoch_seconds_to_calendar_unit_tb.sv =====
// Self-checking testbench for the epoch seconds to calendar date and time converter.
`timescale 1ns / 1ps

module epoch_seconds_to_calendar_unit_tb
   import ecal_pkg::*;
();

   localparam int unsigned LAST_YEAR    = 2038;
   localparam int unsigned RANDOM_BEATS = 400;
   localparam int unsigned QUIET_TAIL   = 60;
   localparam int unsigned LONG_HOLD    = 120;
   localparam int unsigned HOLD_AFTER   = 40;
   localparam int unsigned DRAIN_AT     = 200;
   localparam int unsigned CYCLE_LIMIT  = 300000;
   localparam logic [SECS_W-1:0] SECS_MAX = {SECS_W{1'b1}};

   typedef struct packed {
      logic [YEAR_W-1:0]   year;
      logic [MONTH_W-1:0]  month;
      logic [DAY_W-1:0]    day;
      logic [HOUR_W-1:0]   hour;
      logic [MINUTE_W-1:0] minute;
      logic [SECOND_W-1:0] second;
   } calendar_type;

   typedef struct packed {
      logic [SECS_W-1:0] secs;
      logic              drain_first;
   } epoch_beat_type;

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [SECS_W-1:0]   req_seconds_since_epoch = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [YEAR_W-1:0]   rsp_year;
   logic [MONTH_W-1:0]  rsp_month_index;
   logic [DAY_W-1:0]    rsp_day_of_month;
   logic [HOUR_W-1:0]   rsp_hour_of_day;
   logic [MINUTE_W-1:0] rsp_minute_of_hour;
   logic [SECOND_W-1:0] rsp_second_of_minute;

   epoch_beat_type  seconds_backlog[$];
   calendar_type    calendar_due[$];
   int unsigned  total_beats = 0;
   int unsigned  beats_sent = 0;
   int unsigned  beats_checked = 0;
   int unsigned  leap_days_seen = 0;
   int unsigned  error_count = 0;
   int unsigned  cycle_count = 0;
   logic         beat_taken = 1'b0;
   int unsigned  send_gap = 0;
   int unsigned  rsp_stall = 0;
   int unsigned  long_hold_left = 0;
   logic         long_hold_done = 1'b0;

   epoch_seconds_to_calendar_unit u_dut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_seconds_since_epoch (req_seconds_since_epoch),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_year                (rsp_year),
      .rsp_month_index         (rsp_month_index),
      .rsp_day_of_month        (rsp_day_of_month),
      .rsp_hour_of_day         (rsp_hour_of_day),
      .rsp_minute_of_hour      (rsp_minute_of_hour),
      .rsp_second_of_minute    (rsp_second_of_minute)
   );

   // 4 ns clock
   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   function automatic logic leap_year_of(int unsigned yr);
      return (yr % 4) == 0;
   endfunction

   function automatic int unsigned month_len(int unsigned yr, logic [MONTH_W-1:0] mon);
      case (mon)
         MON_FEB:                             return leap_year_of(yr) ? 29 : 28;
         MON_APR, MON_JUN, MON_SEP, MON_NOV: return 30;
         default:                             return 31;
      endcase
   endfunction

   // Peel off whole years, then whole months, then split the remainder
   function automatic calendar_type predict_calendar(logic [SECS_W-1:0] secs);
      calendar_type       c;
      int unsigned        rest;
      int unsigned        yr;
      logic [MONTH_W-1:0] mon;
      rest = 32'(secs);
      yr   = FIRST_YEAR;
      mon  = MON_JAN;
      while (yr < LAST_YEAR && rest >= (leap_year_of(yr) ? 366 : 365) * SEC_PER_DAY) begin
         rest -= (leap_year_of(yr) ? 366 : 365) * SEC_PER_DAY;
         yr++;
      end
      while (mon < MON_DEC && rest >= month_len(yr, mon) * SEC_PER_DAY) begin
         rest -= month_len(yr, mon) * SEC_PER_DAY;
         mon++;
      end
      c.year   = YEAR_W'(yr);
      c.month  = mon;
      c.day    = DAY_W'(rest / SEC_PER_DAY + 1);
      rest     = rest % SEC_PER_DAY;
      c.hour   = HOUR_W'(rest / SEC_PER_HOUR);
      rest     = rest % SEC_PER_HOUR;
      c.minute = MINUTE_W'(rest / SEC_PER_MIN);
      c.second = SECOND_W'(rest % SEC_PER_MIN);
      return c;
   endfunction

   // Build stimulus from a calendar date and time of day
   function automatic logic [SECS_W-1:0] date_to_seconds(int unsigned yr,
                                                         logic [MONTH_W-1:0] mon,
                                                         int unsigned day, int unsigned hr,
                                                         int unsigned mn, int unsigned sc);
      int unsigned        total;
      int unsigned        y;
      logic [MONTH_W-1:0] m;
      total = 0;
      for (y = FIRST_YEAR; y < yr; y++)
         total += (leap_year_of(y) ? 366 : 365) * SEC_PER_DAY;
      for (m = MON_JAN; m < mon; m++)
         total += month_len(yr, m) * SEC_PER_DAY;
      total += (day - 1) * SEC_PER_DAY + hr * SEC_PER_HOUR + mn * SEC_PER_MIN + sc;
      return SECS_W'(total);
   endfunction

   task automatic queue_secs(logic [SECS_W-1:0] secs);
      epoch_beat_type b;
      b.secs        = secs;
      b.drain_first = (seconds_backlog.size() == DRAIN_AT);
      seconds_backlog.push_back(b);
   endtask

   task automatic check_field(string name, int unsigned want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   // Drive request beats at the falling edge, with idle bursts and one drain pause
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || beat_taken) begin
         if (send_gap != 0) begin
            req_valid <= 1'b0;
            send_gap  <= send_gap - 1;
         end else if (seconds_backlog.size() == 0 ||
                      (seconds_backlog[0].drain_first && calendar_due.size() != 0)) begin
            req_valid <= 1'b0;
         end else if (total_beats - beats_sent > QUIET_TAIL && $urandom_range(0, 11) == 0) begin
            req_valid <= 1'b0;
            send_gap  <= $urandom_range(1, 18) - 1;
         end else begin
            req_valid               <= 1'b1;
            req_seconds_since_epoch <= seconds_backlog[0].secs;
            seconds_backlog.pop_front();
         end
      end
   end

   // Drive rsp_ready: random stall bursts plus one long hold to back up the pipe
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (long_hold_left != 0) begin
         rsp_ready      <= 1'b0;
         long_hold_left <= long_hold_left - 1;
      end else if (!long_hold_done && beats_sent >= HOLD_AFTER) begin
         rsp_ready      <= 1'b0;
         long_hold_done <= 1'b1;
         long_hold_left <= LONG_HOLD - 1;
      end else if (rsp_stall != 0) begin
         rsp_ready <= 1'b0;
         rsp_stall <= rsp_stall - 1;
      end else if (total_beats - beats_checked > QUIET_TAIL && $urandom_range(0, 9) == 0) begin
         rsp_ready <= 1'b0;
         rsp_stall <= $urandom_range(1, 18) - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Predict on each accepted request, check each accepted result
   always @(posedge clock) begin
      calendar_type want;
      if (reset) begin
         beat_taken <= 1'b0;
      end else begin
         beat_taken <= (req_valid && req_ready === 1'b1);
         if (req_valid && req_ready === 1'b1) begin
            want = predict_calendar(req_seconds_since_epoch);
            if (want.month == MON_FEB && want.day == 29)
               leap_days_seen++;
            calendar_due.push_back(want);
            beats_sent++;
         end
         if (rsp_valid === 1'b1 && rsp_ready) begin
            if (calendar_due.size() == 0) begin
               $display("%0t: result with nothing expected, got %0d-%0d-%0d %0d:%0d:%0d",
                        $time, rsp_year, rsp_month_index, rsp_day_of_month,
                        rsp_hour_of_day, rsp_minute_of_hour, rsp_second_of_minute);
               error_count++;
            end else begin
               want = calendar_due.pop_front();
               check_field("year", 32'(want.year), 32'(rsp_year));
               check_field("month_index", 32'(want.month), 32'(rsp_month_index));
               check_field("day_of_month", 32'(want.day), 32'(rsp_day_of_month));
               check_field("hour_of_day", 32'(want.hour), 32'(rsp_hour_of_day));
               check_field("minute_of_hour", 32'(want.minute), 32'(rsp_minute_of_hour));
               check_field("second_of_minute", 32'(want.second),
                           32'(rsp_second_of_minute));
            end
            beats_checked++;
         end
      end
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, calendar_due.size());
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      int unsigned        yr;
      int unsigned        day;
      int unsigned        base;
      int unsigned        kind;
      logic [MONTH_W-1:0] mon;
      logic [SECS_W-1:0]  secs;

      // Directed: range ends, year and month edges, leap Februaries
      queue_secs('0);
      queue_secs(SECS_MAX);
      queue_secs(date_to_seconds(1970, MON_DEC, 31, 23, 59, 59));
      queue_secs(date_to_seconds(1971, MON_JAN, 1, 0, 0, 0));
      queue_secs(date_to_seconds(1972, MON_FEB, 29, 23, 59, 59));
      queue_secs(date_to_seconds(1973, MON_FEB, 28, 23, 59, 59));
      queue_secs(date_to_seconds(1973, MON_MAR, 1, 0, 0, 0));
      queue_secs(date_to_seconds(1999, MON_APR, 30, 23, 59, 59));
      queue_secs(date_to_seconds(2000, MON_DEC, 31, 23, 59, 59));
      queue_secs(date_to_seconds(2037, MON_DEC, 31, 23, 59, 59));
      queue_secs(date_to_seconds(2038, MON_JAN, 1, 0, 0, 0));
      for (mon = MON_JAN; mon <= MON_DEC; mon++)
         queue_secs(date_to_seconds(2024, mon, 1, 0, 0, 0));

      // Random: mostly calendar-shaped values, the rest raw or near the range ends
      for (int unsigned i = 0; i < RANDOM_BEATS; i++) begin
         kind = $urandom_range(0, 9);
         yr   = $urandom_range(FIRST_YEAR, LAST_YEAR - 1);
         mon  = MONTH_W'($urandom_range(MON_JAN, MON_DEC));
         if (kind <= 3) begin
            case ($urandom_range(0, 3))
               0:       day = 1;
               1:       day = month_len(yr, mon);
               default: day = $urandom_range(1, month_len(yr, mon));
            endcase
            secs = date_to_seconds(yr, mon, day, $urandom_range(0, 23),
                                   $urandom_range(0, 59), $urandom_range(0, 59));
         end else if (kind <= 5) begin
            base = 32'(date_to_seconds(yr, mon, 1, 0, 0, 0));
            if (base < 3)
               secs = SECS_W'(base + $urandom_range(0, 3));
            else
               secs = SECS_W'(base + $urandom_range(0, 3) - $urandom_range(0, 3));
         end else if (kind <= 7) begin
            secs = SECS_W'($urandom());
         end else if (kind == 8) begin
            secs = SECS_MAX - SECS_W'($urandom_range(0, 40 * SEC_PER_DAY));
         end else begin
            secs = SECS_W'($urandom_range(0, 100000));
         end
         queue_secs(secs);
      end
      total_beats = seconds_backlog.size();

      // Hold reset, then release it at a falling edge
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait for every beat to go in and every result to come back, then settle
      while (beats_sent != total_beats) @(posedge clock);
      while (calendar_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("%0d conversions checked across 1970 to 2038, %0d landing on a leap day,",
               beats_checked, leap_days_seen);
      $display("with input and output stalls, one full-pipe backpressure hold and one drain.");
      if (error_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// ===== files.f =====
sv/ecal_pkg.sv
sv/ecal_day_split.sv
sv/ecal_date_path.sv
sv/ecal_time_path.sv
sv/epoch_seconds_to_calendar_unit.sv
verif/epoch_seconds_to_calendar_unit_tb.sv
